/* rtl/core/sfdx_pkg.sv */
`default_nettype none
package sfdx_pkg;

	localparam logic [7:0] BYTE_STX = 8'h02;
	localparam logic [7:0] BYTE_CMD = 8'h54;
	localparam logic [7:0] BYTE_ETX = 8'h03;

	localparam logic [1:0] FMT_BYTE   = 2'd0;
	localparam logic [1:0] FMT_TENTHS = 2'd1;
	localparam logic [1:0] FMT_FLOAT  = 2'd2;

	typedef struct packed {
		logic               hit;
		logic [31:0]        payload;
		logic signed [15:0] tenths;
		logic               status;
	} result_t;

endpackage
`default_nettype wire

/* rtl/core/sfdx_parser.sv */
`default_nettype none
module sfdx_parser
	import sfdx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       beat,
	input  wire logic [7:0] rx_byte,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_data,
	output result_t         res
);

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_CMD  = 3'd1;
	localparam logic [2:0] PH_LEN  = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_CHK  = 3'd4;
	localparam logic [2:0] PH_END  = 3'd5;

	logic [1:0]  fmt_q;
	logic [2:0]  phase_q, phase_d;
	logic [2:0]  left_q, left_d;
	logic [7:0]  xor_q, xor_d;
	logic [31:0] shift_q, shift_d;
	logic [7:0]  check_q, check_d;

	logic [2:0]  want;
	logic [2:0]  left_dec;
	logic [15:0] sx;

	always_comb begin
		unique case (fmt_q)
			FMT_BYTE:   want = 3'd1;
			FMT_TENTHS: want = 3'd2;
			FMT_FLOAT:  want = 3'd4;
			default:    want = 3'd0;
		endcase
	end

	assign left_dec = left_q - 3'd1;
	assign sx       = {{8{shift_q[7]}}, shift_q[7:0]};

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		xor_d   = xor_q;
		shift_d = shift_q;
		check_d = check_q;
		res.hit     = 1'b0;
		res.payload = shift_q;
		res.status  = (xor_q != check_q);
		case (fmt_q)
			FMT_BYTE:   res.tenths = (sx << 3) + (sx << 1);
			FMT_TENTHS: res.tenths = shift_q[15:0];
			default:    res.tenths = 16'sd0;
		endcase

		unique case (phase_q)
			PH_CMD: begin
				if (rx_byte == BYTE_CMD) begin
					xor_d   = BYTE_CMD;
					phase_d = PH_LEN;
				end else begin
					phase_d = (rx_byte == BYTE_STX) ? PH_CMD : PH_HUNT;
					left_d  = 3'd0;
					xor_d   = 8'd0;
					shift_d = 32'd0;
					check_d = 8'd0;
				end
			end
			PH_LEN: begin
				if (want != 3'd0 && rx_byte == {5'd0, want}) begin
					xor_d   = xor_q ^ rx_byte;
					left_d  = rx_byte[2:0];
					shift_d = 32'd0;
					phase_d = PH_DATA;
				end else begin
					phase_d = (rx_byte == BYTE_STX) ? PH_CMD : PH_HUNT;
					left_d  = 3'd0;
					xor_d   = 8'd0;
					shift_d = 32'd0;
					check_d = 8'd0;
				end
			end
			PH_DATA: begin
				shift_d = {shift_q[23:0], rx_byte};
				xor_d   = xor_q ^ rx_byte;
				left_d  = left_dec;
				if (left_dec == 3'd0) begin
					phase_d = PH_CHK;
				end
			end
			PH_CHK: begin
				check_d = rx_byte;
				phase_d = PH_END;
			end
			PH_END: begin
				if (rx_byte == BYTE_ETX) begin
					res.hit = 1'b1;
					phase_d = PH_HUNT;
				end else begin
					phase_d = (rx_byte == BYTE_STX) ? PH_CMD : PH_HUNT;
				end
				left_d  = 3'd0;
				xor_d   = 8'd0;
				shift_d = 32'd0;
				check_d = 8'd0;
			end
			default: begin
				phase_d = (rx_byte == BYTE_STX) ? PH_CMD : PH_HUNT;
				left_d  = 3'd0;
				xor_d   = 8'd0;
				shift_d = 32'd0;
				check_d = 8'd0;
			end
		endcase

		if (!beat) begin
			res.hit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_BYTE;
			phase_q <= PH_HUNT;
			left_q  <= 3'd0;
			xor_q   <= 8'd0;
			shift_q <= 32'd0;
			check_q <= 8'd0;
		end else begin
			if (cfg_we) begin
				fmt_q <= cfg_data;
			end
			if (beat) begin
				phase_q <= phase_d;
				left_q  <= left_d;
				xor_q   <= xor_d;
				shift_q <= shift_d;
				check_q <= check_d;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/sensor_frame_deframer_xor_check.sv */
// A result from the ETX beat is registered in the output or the skid slot.
// Throughput: one byte per cycle; input stalls only while a second result
//   waits behind a held result under out_stall.
// Reset (arst_n low, asynchronous): parser returns to hunting for STX,
//   format returns to signed byte, no result pending.
`default_nettype none
module sensor_frame_deframer_xor_check
	import sfdx_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [31:0]             payload_raw,
	output logic signed [15:0]      temp_tenths,
	output logic                    frame_status
);

	logic    beat;
	result_t res;
	logic    out_valid_q;
	result_t res_q;
	logic    skid_valid_q;
	result_t skid_q;
	logic    out_take;

	assign in_stall = skid_valid_q;
	assign beat     = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;

	sfdx_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.beat     (beat),
		.rx_byte  (rx_byte),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.res      (res)
	);

	// hold while stalled and park a new result in the skid slot;
	// otherwise load the parked or the next result, or drop valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			res_q        <= '0;
			skid_valid_q <= 1'b0;
			skid_q       <= '0;
		end else if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				res_q        <= skid_q;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res.hit;
				if (res.hit) begin
					res_q <= res;
				end
			end
		end else if (res.hit) begin
			skid_valid_q <= 1'b1;
			skid_q       <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_raw  = res_q.payload;
	assign temp_tenths  = res_q.tenths;
	assign frame_status = res_q.status;

endmodule
`default_nettype wire

/* rtl/core/sfdx_checker.sv */
`default_nettype none
module sfdx_checker
	import sfdx_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic [7:0]         rx_byte,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [31:0]        payload_raw,
	input wire logic signed [15:0] temp_tenths,
	input wire logic               frame_status
);

	a_hold_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_raw)
			&& $stable(temp_tenths) && $stable(frame_status))
		else $error("stalled result beat changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled without a held result");

	a_etx_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid)
			|-> $past(in_valid && !in_stall && rx_byte == BYTE_ETX))
		else $error("result without an ETX beat");

endmodule

bind sensor_frame_deframer_xor_check sfdx_checker u_sfdx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.rx_byte      (rx_byte),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.payload_raw  (payload_raw),
	.temp_tenths  (temp_tenths),
	.frame_status (frame_status)
);
`default_nettype wire

/* bench/tb_top.sv */
module tb_top;
	import sfdx_pkg::*;

	localparam logic [1:0] FMT_NONE = 2'd3;

	typedef enum logic [2:0] {
		SEEK_STX, WANT_CMD, WANT_LEN, TAKE_DATA, TAKE_CHK, WANT_ETX
	} parse_at_t;

	typedef struct {
		logic [31:0]        payload;
		logic signed [15:0] tenths;
		logic               status;
	} frame_rep_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_data = FMT_BYTE;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] payload_raw;
	logic signed [15:0] temp_tenths;
	logic frame_status;

	sensor_frame_deframer_xor_check u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_raw  (payload_raw),
		.temp_tenths  (temp_tenths),
		.frame_status (frame_status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [7:0] rx_pending[$];
	logic [7:0] frame_buf[$];
	frame_rep_t frames_due[$];

	logic [1:0]  fmt_now = FMT_BYTE;
	parse_at_t   parse_at = SEEK_STX;
	logic [2:0]  data_left = '0;
	logic [7:0]  xor_sum = '0;
	logic [31:0] data_word = '0;
	logic [7:0]  chk_byte = '0;

	logic in_taken = 1'b0;
	logic calm = 1'b0;
	logic rx_hold = 1'b0;
	int errors = 0;
	int beats_in = 0;
	int stim_bytes = 0;
	int frames_seen = 0;
	int bad_seen = 0;
	int formats_set = 0;

	task automatic note_error(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic [7:0] frame_len(input logic [1:0] f);
		case (f)
		FMT_BYTE:   return 8'd1;
		FMT_TENTHS: return 8'd2;
		FMT_FLOAT:  return 8'd4;
		default:    return 8'd0;
		endcase
	endfunction

	function automatic logic signed [15:0] tenths_for(input logic [31:0] w);
		logic signed [15:0] deg;
		deg = {{8{w[7]}}, w[7:0]};
		case (fmt_now)
		FMT_BYTE:   return deg * 16'sd10;
		FMT_TENTHS: return w[15:0];
		default:    return '0;
		endcase
	endfunction

	function automatic void hunt_from(input logic [7:0] b);
		parse_at = (b == BYTE_STX) ? WANT_CMD : SEEK_STX;
		data_left = '0;
		xor_sum = '0;
		data_word = '0;
		chk_byte = '0;
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		frame_rep_t rep;
		case (parse_at)
		WANT_CMD: begin
			if (b == BYTE_CMD) begin
				xor_sum = BYTE_CMD;
				parse_at = WANT_LEN;
			end else
				hunt_from(b);
		end
		WANT_LEN: begin
			if (frame_len(fmt_now) != 8'd0 && b == frame_len(fmt_now)) begin
				xor_sum ^= b;
				data_left = b[2:0];
				data_word = '0;
				parse_at = TAKE_DATA;
			end else
				hunt_from(b);
		end
		TAKE_DATA: begin
			data_word = {data_word[23:0], b};
			xor_sum ^= b;
			data_left = data_left - 3'd1;
			if (data_left == 3'd0)
				parse_at = TAKE_CHK;
		end
		TAKE_CHK: begin
			chk_byte = b;
			parse_at = WANT_ETX;
		end
		WANT_ETX: begin
			if (b == BYTE_ETX) begin
				rep.payload = data_word;
				rep.tenths = tenths_for(data_word);
				rep.status = (xor_sum != chk_byte);
				frames_due.insert(frames_due.size(), rep);
				hunt_from(8'h00);
			end else
				hunt_from(b);
		end
		default: hunt_from(b);
		endcase
	endfunction

	task automatic check_frame();
		frame_rep_t want;
		frames_seen++;
		if (frame_status)
			bad_seen++;
		if (frames_due.size() == 0) begin
			note_error($sformatf("unexpected frame, payload %h", payload_raw));
			return;
		end
		want = frames_due.pop_front();
		if (payload_raw !== want.payload)
			note_error($sformatf("payload_raw %h, want %h", payload_raw, want.payload));
		if (temp_tenths !== want.tenths)
			note_error($sformatf("temp_tenths %0d, want %0d", temp_tenths, want.tenths));
		if (frame_status !== want.status)
			note_error($sformatf("frame_status %b, want %b", frame_status, want.status));
	endtask

	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (arst_n && cfg_we)
			fmt_now = cfg_data;
		if (in_taken) begin
			beats_in++;
			parse_byte(rx_byte);
		end
		if (arst_n && out_valid && !out_stall)
			check_frame();
	end

	// advance only once the current beat is gone; hold it otherwise
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (rx_pending.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
				in_valid <= 1'b1;
				rx_byte <= rx_pending.pop_front();
			end else begin
				in_valid <= 1'b0;
				rx_byte <= 8'($urandom);
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= rx_hold || (!calm && $urandom_range(99) < 36);
	end

	initial begin
		wait (beats_in >= 250);
		rx_hold = 1'b1;
		repeat (150) @(posedge clk);
		rx_hold = 1'b0;
	end

	function automatic logic [31:0] pick_payload(input logic [7:0] len);
		logic [31:0] mask;
		mask = 32'hFFFF_FFFF >> (32 - 8 * int'(len));
		if ($urandom_range(7) != 0)
			return $urandom & mask;
		case ($urandom_range(3))
		0:       return 32'h0;
		1:       return mask;
		2:       return (mask >> 1) + 32'd1;
		default: return mask >> 1;
		endcase
	endfunction

	function automatic void build_frame(input logic [7:0] len, input logic [31:0] data,
			input logic [7:0] flip, input logic [7:0] tail);
		logic [7:0] sum;
		frame_buf = {BYTE_STX, BYTE_CMD, len};
		sum = BYTE_CMD ^ len;
		for (int i = int'(len) - 1; i >= 0; i--) begin
			frame_buf.insert(frame_buf.size(), data[8*i +: 8]);
			sum ^= data[8*i +: 8];
		end
		frame_buf.insert(frame_buf.size(), sum ^ flip);
		frame_buf.insert(frame_buf.size(), tail);
	endfunction

	function automatic void send_bytes(input logic [7:0] b[$]);
		foreach (b[i])
			rx_pending.insert(rx_pending.size(), b[i]);
		stim_bytes += b.size();
	endfunction

	task automatic settle();
		do
			@(negedge clk);
		while (rx_pending.size() != 0 || in_valid || frames_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_format(input logic [1:0] f);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= f;
		@(negedge clk);
		cfg_we <= 1'b0;
		formats_set++;
	endtask

	task automatic add_random(input int n, input logic [1:0] f);
		int stop;
		int pos;
		int r;
		logic [7:0] len;
		stop = stim_bytes + n;
		while (stim_bytes < stop) begin
			r = $urandom_range(99);
			len = (f == FMT_NONE) ? 8'(1 << $urandom_range(2)) : frame_len(f);
			build_frame(len, pick_payload(len),
				($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00, BYTE_ETX);
			if (r >= 90) begin
				frame_buf = {};
				repeat ($urandom_range(1, 4))
					frame_buf.insert(frame_buf.size(), 8'($urandom));
			end else if (r >= 70) begin
				pos = $urandom_range(frame_buf.size() - 1);
				frame_buf[pos] = 8'($urandom);
				if ($urandom_range(1) == 1)
					frame_buf = frame_buf[0:pos];
			end
			send_bytes(frame_buf);
		end
	endtask

	initial begin
		logic [1:0] plan[6];
		plan = '{FMT_TENTHS, FMT_FLOAT, FMT_NONE, FMT_BYTE, FMT_FLOAT, FMT_TENTHS};
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed beats under the reset format
		build_frame(8'd1, 32'h80, 8'h00, BYTE_ETX);
		send_bytes(frame_buf);
		build_frame(8'd1, 32'h7F, 8'h5A, BYTE_ETX);
		send_bytes(frame_buf);
		send_bytes('{BYTE_STX, 8'h55});
		send_bytes('{BYTE_STX, BYTE_STX, BYTE_CMD, 8'd2});
		build_frame(8'd1, 32'h03, 8'h00, BYTE_STX);
		send_bytes(frame_buf);
		build_frame(8'd1, 32'hFF, 8'h00, BYTE_ETX);
		void'(frame_buf.pop_front());
		send_bytes(frame_buf);

		// switch format between checksum and end byte
		build_frame(8'd1, 32'hC8, 8'h00, BYTE_ETX);
		frame_buf = frame_buf[0:$-1];
		send_bytes(frame_buf);
		set_format(FMT_TENTHS);
		send_bytes('{BYTE_ETX});

		// switch format between command and length
		send_bytes('{BYTE_STX, BYTE_CMD});
		set_format(FMT_FLOAT);
		build_frame(8'd4, 32'h8000_0001, 8'h00, BYTE_ETX);
		void'(frame_buf.pop_front());
		void'(frame_buf.pop_front());
		send_bytes(frame_buf);

		foreach (plan[i]) begin
			set_format(plan[i]);
			@(posedge clk);
			calm = (i == 1);
			add_random(175, plan[i]);
		end
		settle();
		calm = 1'b0;
		repeat (10) @(posedge clk);
		if (frames_due.size() != 0)
			note_error($sformatf("%0d frames never reported", frames_due.size()));

		$display("Run covered %0d input beats and %0d format writes, incl. all four codes.",
			beats_in, formats_set);
		$display("Checked %0d reported frames, %0d of them with a checksum mismatch.",
			frames_seen, bad_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
